// ===== hdl/s5c_pkg.sv =====
// Shared types, protocol constants and greeting tables for the SOCKS5 client reply engine.
// No dependencies; the parser, result queue, top level and checker in hdl/ import this package.
package s5c_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int LEN_W       = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_AUTH_POLICY   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECEIVE_LIMIT = 1'b1;

    localparam logic [1:0]       POLICY_RESET = 2'd0;
    localparam logic [LEN_W-1:0] LIMIT_RESET  = 9'd262;

    localparam logic [1:0] POL_ANON     = 2'd0;
    localparam logic [1:0] POL_USERPASS = 2'd1;

    // Result kinds.
    localparam logic [2:0] K_GREET   = 3'd0;
    localparam logic [2:0] K_AUTHREQ = 3'd1;
    localparam logic [2:0] K_CONNREQ = 3'd2;
    localparam logic [2:0] K_BOUND   = 3'd3;
    localparam logic [2:0] K_READY   = 3'd4;
    localparam logic [2:0] K_FAIL    = 3'd5;

    // Failure codes.
    localparam logic [3:0] F_NONE        = 4'd0;
    localparam logic [3:0] F_BAD_VERSION = 4'd1;
    localparam logic [3:0] F_ALL_REJECT  = 4'd2;
    localparam logic [3:0] F_DISALLOWED  = 4'd3;
    localparam logic [3:0] F_AUTH_REJECT = 4'd4;
    localparam logic [3:0] F_BAD_HEADER  = 4'd5;
    localparam logic [3:0] F_SERVER_ERR  = 4'd6;
    localparam logic [3:0] F_BAD_ATYP    = 4'd7;
    localparam logic [3:0] F_EMPTY_HOST  = 4'd8;
    localparam logic [3:0] F_OVER_LIMIT  = 4'd9;
    localparam logic [3:0] F_IDLE_BYTE   = 4'd10;

    // Protocol bytes.
    localparam logic [7:0] VER_SOCKS5      = 8'h05;
    localparam logic [7:0] VER_AUTH        = 8'h01;
    localparam logic [7:0] METHOD_NONE     = 8'h00;
    localparam logic [7:0] METHOD_USERPASS = 8'h02;
    localparam logic [7:0] METHOD_REJECT   = 8'hFF;
    localparam logic [7:0] NMETHODS_ONE    = 8'h01;
    localparam logic [7:0] NMETHODS_TWO    = 8'h02;
    localparam logic [7:0] ATYP_IPV4       = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN     = 8'h03;
    localparam logic [7:0] ATYP_IPV6       = 8'h04;

    localparam logic [LEN_W-1:0] REPLY_LEN_IPV4 = 9'd10;
    localparam logic [LEN_W-1:0] REPLY_LEN_IPV6 = 9'd22;
    localparam logic [LEN_W-1:0] REPLY_LEN_HOST = 9'd7;

    // Bound address kinds.
    localparam logic [1:0] BT_IPV4 = 2'd0;
    localparam logic [1:0] BT_HOST = 2'd1;
    localparam logic [1:0] BT_IPV6 = 2'd2;

    // One queued result; a greeting entry expands into several beats.
    typedef struct packed {
        logic        greet;
        logic [1:0]  policy;
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [3:0]  fail_code;
        logic [7:0]  server_code;
        logic [1:0]  bound_type;
        logic [15:0] bound_port;
    } s5c_desc_t;

    typedef struct packed {
        logic      valid;
        s5c_desc_t desc;
    } s5c_push_t;

    // Index of the final greeting byte for a policy.
    function automatic logic [1:0] greet_last_idx(input logic [1:0] policy);
        greet_last_idx = (policy == POL_ANON || policy == POL_USERPASS) ? 2'd2 : 2'd3;
    endfunction

    function automatic logic [7:0] greet_byte(input logic [1:0] policy,
                                              input logic [1:0] idx);
        logic [7:0] b;
        b = VER_SOCKS5;
        case (idx)
            2'd0: b = VER_SOCKS5;
            2'd1: b = (policy == POL_ANON || policy == POL_USERPASS) ?
                      NMETHODS_ONE : NMETHODS_TWO;
            2'd2: b = (policy == POL_USERPASS) ? METHOD_USERPASS : METHOD_NONE;
            2'd3: b = METHOD_USERPASS;
            default: b = VER_SOCKS5;
        endcase
        greet_byte = b;
    endfunction

endpackage

// ===== hdl/s5c_in_if.sv =====
// Input channel: valid/ready handshake carrying one command or server byte per beat.
// Standalone; no package dependency.
interface s5c_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

// ===== hdl/s5c_out_if.sv =====
// Result channel: valid/ready handshake carrying one result beat.
// Standalone; no package dependency.
interface s5c_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [3:0]  fail_code;
    logic [7:0]  server_code;
    logic [1:0]  bound_type;
    logic [15:0] bound_port;

    modport source (output valid, output kind, output data_byte, output last,
                    output fail_code, output server_code, output bound_type,
                    output bound_port, input ready);
    modport sink   (input valid, input kind, input data_byte, input last,
                    input fail_code, input server_code, input bound_type,
                    input bound_port, output ready);
endinterface

// ===== hdl/s5c_parser.sv =====
// Input register, configuration registers and the handshake parser state.
// Depends on s5c_pkg; pushes one result entry per producing beat into s5c_result_queue.
module s5c_parser
    import s5c_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_func,
    input  logic [7:0]             in_byte,
    input  logic                   q_room,
    output s5c_push_t              push
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_METHOD,
        ST_AUTH,
        ST_CONNECT,
        ST_READY,
        ST_FAILED
    } stage_t;

    logic             item_valid_reg;
    logic             item_func_reg;
    logic [7:0]       item_byte_reg;
    logic [1:0]       auth_policy_reg;
    logic [LEN_W-1:0] receive_limit_reg;

    stage_t           stage_reg, stage_next;
    logic [LEN_W-1:0] byte_index_reg, byte_index_next;
    logic [LEN_W-1:0] reply_length_reg, reply_length_next;
    logic [1:0]       address_kind_reg, address_kind_next;
    logic [7:0]       port_high_reg, port_high_next;
    logic [7:0]       reply_code_reg, reply_code_next;

    logic             fire;
    logic             res_valid;
    logic             res_greet;
    logic [2:0]       res_kind;
    logic [7:0]       res_data;
    logic [3:0]       res_fail;
    logic [15:0]      res_port;
    logic [LEN_W:0]   idx_plus1;
    logic [LEN_W:0]   idx_plus2;
    logic [LEN_W-1:0] host_len;
    logic             method_ok;

    assign in_ready  = !item_valid_reg || q_room;
    assign fire      = item_valid_reg && q_room;
    assign idx_plus1 = {1'b0, byte_index_reg} + 10'd1;
    assign idx_plus2 = {1'b0, byte_index_reg} + 10'd2;
    assign host_len  = REPLY_LEN_HOST + {1'b0, item_byte_reg};
    assign method_ok = (item_byte_reg == METHOD_NONE && auth_policy_reg != POL_USERPASS) ||
                       (item_byte_reg == METHOD_USERPASS && auth_policy_reg != POL_ANON);

    always_comb
    begin
        stage_next        = stage_reg;
        byte_index_next   = byte_index_reg;
        reply_length_next = reply_length_reg;
        address_kind_next = address_kind_reg;
        port_high_next    = port_high_reg;
        reply_code_next   = reply_code_reg;
        res_valid         = 1'b0;
        res_greet         = 1'b0;
        res_kind          = K_FAIL;
        res_data          = 8'd0;
        res_fail          = F_NONE;
        res_port          = 16'd0;

        if (!item_func_reg)
        begin
            stage_next        = ST_METHOD;
            byte_index_next   = '0;
            reply_length_next = '0;
            address_kind_next = BT_IPV4;
            port_high_next    = 8'd0;
            reply_code_next   = 8'd0;
            res_valid         = 1'b1;
            res_greet         = 1'b1;
            res_kind          = K_GREET;
        end
        else
        begin
            case (stage_reg)
                ST_METHOD:
                begin
                    res_valid = 1'b1;
                    if (byte_index_reg == '0)
                    begin
                        if (item_byte_reg != VER_SOCKS5)
                        begin
                            stage_next = ST_FAILED;
                            res_fail   = F_BAD_VERSION;
                        end
                        else
                        begin
                            byte_index_next = 9'd1;
                            res_valid       = 1'b0;
                        end
                    end
                    else if (item_byte_reg == METHOD_REJECT)
                    begin
                        stage_next = ST_FAILED;
                        res_fail   = F_ALL_REJECT;
                    end
                    else if (!method_ok)
                    begin
                        stage_next = ST_FAILED;
                        res_fail   = F_DISALLOWED;
                    end
                    else
                    begin
                        byte_index_next = '0;
                        if (item_byte_reg == METHOD_USERPASS)
                        begin
                            stage_next = ST_AUTH;
                            res_kind   = K_AUTHREQ;
                        end
                        else
                        begin
                            stage_next = ST_CONNECT;
                            res_kind   = K_CONNREQ;
                        end
                    end
                end
                ST_AUTH:
                begin
                    res_valid = 1'b1;
                    if (byte_index_reg == '0)
                    begin
                        if (item_byte_reg != VER_AUTH)
                        begin
                            stage_next = ST_FAILED;
                            res_fail   = F_BAD_VERSION;
                        end
                        else
                        begin
                            byte_index_next = 9'd1;
                            res_valid       = 1'b0;
                        end
                    end
                    else if (item_byte_reg != 8'd0)
                    begin
                        stage_next = ST_FAILED;
                        res_fail   = F_AUTH_REJECT;
                    end
                    else
                    begin
                        byte_index_next = '0;
                        stage_next      = ST_CONNECT;
                        res_kind        = K_CONNREQ;
                    end
                end
                ST_CONNECT:
                begin
                    res_valid = 1'b1;
                    if (byte_index_reg == 9'd0)
                    begin
                        if (item_byte_reg != VER_SOCKS5)
                        begin
                            stage_next = ST_FAILED;
                            res_fail   = F_BAD_HEADER;
                        end
                        else
                        begin
                            byte_index_next = 9'd1;
                            res_valid       = 1'b0;
                        end
                    end
                    else if (byte_index_reg == 9'd1)
                    begin
                        // The server code waits in port_high until the reserved byte checks out.
                        port_high_next  = item_byte_reg;
                        byte_index_next = 9'd2;
                        res_valid       = 1'b0;
                    end
                    else if (byte_index_reg == 9'd2)
                    begin
                        if (item_byte_reg != 8'd0)
                        begin
                            stage_next = ST_FAILED;
                            res_fail   = F_BAD_HEADER;
                        end
                        else
                        begin
                            reply_code_next = port_high_reg;
                            port_high_next  = 8'd0;
                            if (port_high_reg != 8'd0)
                            begin
                                stage_next = ST_FAILED;
                                res_fail   = F_SERVER_ERR;
                            end
                            else
                            begin
                                byte_index_next = 9'd3;
                                res_valid       = 1'b0;
                            end
                        end
                    end
                    else if (byte_index_reg == 9'd3)
                    begin
                        if (item_byte_reg == ATYP_IPV4 || item_byte_reg == ATYP_IPV6)
                        begin
                            address_kind_next = (item_byte_reg == ATYP_IPV4) ? BT_IPV4 : BT_IPV6;
                            reply_length_next = (item_byte_reg == ATYP_IPV4) ?
                                                REPLY_LEN_IPV4 : REPLY_LEN_IPV6;
                            if (reply_length_next > receive_limit_reg)
                            begin
                                stage_next = ST_FAILED;
                                res_fail   = F_OVER_LIMIT;
                            end
                            else
                            begin
                                byte_index_next = 9'd4;
                                res_valid       = 1'b0;
                            end
                        end
                        else if (item_byte_reg == ATYP_DOMAIN)
                        begin
                            address_kind_next = BT_HOST;
                            byte_index_next   = 9'd4;
                            res_valid         = 1'b0;
                        end
                        else
                        begin
                            stage_next = ST_FAILED;
                            res_fail   = F_BAD_ATYP;
                        end
                    end
                    else if (byte_index_reg == 9'd4 && address_kind_reg == BT_HOST)
                    begin
                        if (item_byte_reg == 8'd0)
                        begin
                            stage_next = ST_FAILED;
                            res_fail   = F_EMPTY_HOST;
                        end
                        else
                        begin
                            reply_length_next = host_len;
                            if (host_len > receive_limit_reg)
                            begin
                                stage_next = ST_FAILED;
                                res_fail   = F_OVER_LIMIT;
                            end
                            else
                            begin
                                byte_index_next = 9'd5;
                                res_valid       = 1'b0;
                            end
                        end
                    end
                    else if (idx_plus2 == {1'b0, reply_length_reg})
                    begin
                        port_high_next  = item_byte_reg;
                        byte_index_next = idx_plus1[LEN_W-1:0];
                        res_valid       = 1'b0;
                    end
                    else if (idx_plus1 == {1'b0, reply_length_reg})
                    begin
                        stage_next      = ST_READY;
                        byte_index_next = '0;
                        res_kind        = K_READY;
                        res_port        = {port_high_reg, item_byte_reg};
                    end
                    else
                    begin
                        byte_index_next = idx_plus1[LEN_W-1:0];
                        res_kind        = K_BOUND;
                        res_data        = item_byte_reg;
                    end
                end
                default:
                begin
                    // A byte with no handshake in progress fails but leaves the state alone.
                    res_valid = 1'b1;
                    res_fail  = F_IDLE_BYTE;
                end
            endcase
        end
    end

    always_comb
    begin
        push.valid            = fire && res_valid;
        push.desc.greet       = res_greet;
        push.desc.policy      = auth_policy_reg;
        push.desc.kind        = res_kind;
        push.desc.data_byte   = res_data;
        push.desc.fail_code   = res_fail;
        push.desc.server_code = reply_code_next;
        push.desc.bound_type  = address_kind_next;
        push.desc.bound_port  = res_port;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg    <= 1'b0;
            auth_policy_reg   <= POLICY_RESET;
            receive_limit_reg <= LIMIT_RESET;
            stage_reg         <= ST_IDLE;
            byte_index_reg    <= '0;
            reply_length_reg  <= '0;
            address_kind_reg  <= BT_IPV4;
            port_high_reg     <= 8'd0;
            reply_code_reg    <= 8'd0;
        end
        else
        begin
            if (in_valid && in_ready)
                item_valid_reg <= 1'b1;
            else if (fire)
                item_valid_reg <= 1'b0;

            if (cfg_we && cfg_index == CFG_AUTH_POLICY)
                auth_policy_reg <= cfg_data[1:0];
            if (cfg_we && cfg_index == CFG_RECEIVE_LIMIT)
                receive_limit_reg <= cfg_data[LEN_W-1:0];

            if (fire)
            begin
                stage_reg        <= stage_next;
                byte_index_reg   <= byte_index_next;
                reply_length_reg <= reply_length_next;
                address_kind_reg <= address_kind_next;
                port_high_reg    <= port_high_next;
                reply_code_reg   <= reply_code_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_func_reg <= in_func;
            item_byte_reg <= in_byte;
        end
    end

endmodule

// ===== hdl/s5c_result_queue.sv =====
// Two-entry result queue that drives the output beats; greeting entries expand into 3 or 4 beats.
// Depends on s5c_pkg.
module s5c_result_queue
    import s5c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  s5c_push_t   push,
    output logic        q_room,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_kind,
    output logic [7:0]  out_data_byte,
    output logic        out_last,
    output logic [3:0]  out_fail_code,
    output logic [7:0]  out_server_code,
    output logic [1:0]  out_bound_type,
    output logic [15:0] out_bound_port
);

    localparam int DEPTH = 2;

    s5c_desc_t  entry_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] beat_reg;
    s5c_desc_t  head;
    logic       beat_last;
    logic       beat_take;
    logic       pop;

    assign head      = entry_reg[rd_ptr_reg];
    assign q_room    = count_reg != 2'(DEPTH);
    assign beat_last = !head.greet || (beat_reg == greet_last_idx(head.policy));
    assign beat_take = out_valid && out_ready;
    assign pop       = beat_take && beat_last;

    assign out_valid       = count_reg != 2'd0;
    assign out_kind        = head.greet ? K_GREET : head.kind;
    assign out_data_byte   = head.greet ? greet_byte(head.policy, beat_reg) : head.data_byte;
    assign out_last        = beat_last;
    assign out_fail_code   = head.fail_code;
    assign out_server_code = head.server_code;
    assign out_bound_type  = head.bound_type;
    assign out_bound_port  = head.bound_port;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            beat_reg   <= 2'd0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push.valid && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push.valid)
                count_reg <= count_reg - 2'd1;

            if (pop)
                beat_reg <= 2'd0;
            else if (beat_take)
                beat_reg <= beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.desc;
    end

endmodule

// ===== hdl/socks5_client_reply_engine.sv =====
// A beat accepted on req passes the parser's input register and then a result queue entry before it shows on rsp.
// Throughput: one req beat per cycle while rsp keeps up; a start beat occupies rsp for
// three or four greeting beats, and the two-entry result queue sets how far req may run ahead.
// Beats that complete nothing produce no result; they only pass through the parser's input register.
// Reset (rst_n low, asynchronous) empties both stages, returns the handshake to idle and loads
// auth_policy 0 and receive_limit 262.
module socks5_client_reply_engine
    import s5c_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    s5c_in_if.sink                 req,
    s5c_out_if.source              rsp
);

    s5c_push_t push;
    logic      q_room;

    s5c_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_func   (req.func),
        .in_byte   (req.rx_byte),
        .q_room    (q_room),
        .push      (push)
    );

    s5c_result_queue u_queue (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .q_room          (q_room),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_kind        (rsp.kind),
        .out_data_byte   (rsp.data_byte),
        .out_last        (rsp.last),
        .out_fail_code   (rsp.fail_code),
        .out_server_code (rsp.server_code),
        .out_bound_type  (rsp.bound_type),
        .out_bound_port  (rsp.bound_port)
    );

endmodule

// ===== hdl/s5c_checker.sv =====
// Port-level checks on the result channel of socks5_client_reply_engine, with the bind.
// Depends on s5c_pkg and the top level's port list.
module s5c_checker
    import s5c_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  rsp_kind,
    input logic [7:0]  rsp_data_byte,
    input logic        rsp_last,
    input logic [3:0]  rsp_fail_code,
    input logic [15:0] rsp_bound_port
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
        $stable(rsp_data_byte) && $stable(rsp_last))
        else $error("result beat changed while stalled");

    a_fail_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_kind == K_FAIL) == (rsp_fail_code != F_NONE)))
        else $error("failure code does not match result kind");

    a_port_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind != K_READY |-> rsp_bound_port == 16'd0)
        else $error("bound port shown outside a ready result");

    a_data_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind != K_GREET && rsp_kind != K_BOUND |-> rsp_data_byte == 8'd0)
        else $error("data byte set on a result that carries none");

    a_greet_run: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_kind == K_GREET)
        else $error("multi-beat result broken before its last beat");

endmodule

bind socks5_client_reply_engine s5c_checker u_s5c_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_kind       (rsp.kind),
    .rsp_data_byte  (rsp.data_byte),
    .rsp_last       (rsp.last),
    .rsp_fail_code  (rsp.fail_code),
    .rsp_bound_port (rsp.bound_port)
);
